// File: design/first_fit_block_allocator_macros.svh
// assertion macros used by the allocator top level
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// property checked on clk_i, off while rst_ni is low
`define FFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// property checked on clk_i, also during reset
`define FFBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FFBA_ASSERT(lbl, prop, msg)
`define FFBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: design/ffba_pkg.sv
// types and constants of the first-fit block allocator
package ffba_pkg;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_BASE_ADDRESS = 1'b0;

  localparam logic [31:0] BASE_ADDRESS_RESET = 32'h2000_1000;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_SIZE  = 2'd1,
    STATUS_NO_FIT    = 2'd2,
    STATUS_IGNORED   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_MARK,
    S_FREE_CHK,
    S_RELEASE,
    S_RESP
  } state_e;

endpackage

// File: design/ffba_if.sv
// request and response channel interfaces of the allocator

interface ffba_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] alloc_bytes;
  logic [31:0] free_address;

  modport source (output valid, output cmd, output alloc_bytes, output free_address,
                  input ready);
  modport sink (input valid, input cmd, input alloc_bytes, input free_address,
                output ready);
endinterface

interface ffba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_address;

  modport source (output valid, output status, output result_address, input ready);
  modport sink (input valid, input status, input result_address, output ready);
endinterface

// File: design/ffba_cdiv.sv
// constant divider by reciprocal multiplication, quotient registered on start and valid in the next cycle
module ffba_cdiv #(
  parameter int DIVIDEND_W = 17,
  parameter int DIVISOR    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quot_o
);

  // reciprocal exact for every dividend below 2**DIVIDEND_W
  localparam int ShiftW = DIVIDEND_W + $clog2(DIVISOR);
  localparam int RecipW = DIVIDEND_W + 1;
  localparam int ProdW  = RecipW + DIVIDEND_W;
  localparam longint unsigned RecipL =
    ((64'd1 << ShiftW) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);

  logic [ProdW-1:0]      prod;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic                  done_q, done_d;

  // multiply by the scaled reciprocal, keep the bits above the scale
  always_comb begin
    prod   = ProdW'(dividend_i) * ProdW'(Recip);
    quo_d  = DIVIDEND_W'(prod >> ShiftW);
    done_d = start_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: design/first_fit_block_allocator.sv
// first-fit block allocator top level: block table memory, sequencer, constant divider, apb register, response register
// Allocates and frees runs of BLOCK_BYTES-sized blocks in a heap of BLOCK_TOTAL blocks
// starting at base_address. One request is handled at a time; the block table sits in a
// single-port-per-direction synchronous memory that is walked one entry per cycle. After
// reset a clearing pass writes every table entry to free, during which no request beat is
// accepted (register writes are). A request is then accepted, passes the constant divider
// and ends in a response step that waits for the output register; in between, allocate
// reads the table entries up to the end of the first fitting run and then writes each block
// of the run, while free reads the run head and writes each block released. A size or
// address rejected at accept skips the divider. A finished response waits in an output
// register, so the next request is taken while it is still pending.
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int BLOCK_BYTES = 16,
  parameter int BLOCK_TOTAL = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request and response channels
  ffba_req_if.sink    req_i,
  ffba_rsp_if.source  rsp_o
);

  `include "first_fit_block_allocator_macros.svh"

  localparam int HeapBytesInt = BLOCK_BYTES * BLOCK_TOTAL;
  localparam int HeapW  = $clog2(HeapBytesInt);
  localparam int DivW   = (HeapW > 17) ? HeapW : 17;
  localparam int IdxW   = $clog2(BLOCK_TOTAL);
  localparam int CntW   = $clog2(BLOCK_TOTAL + 1);
  localparam int MarkW  = $clog2(BLOCK_TOTAL + 2);

  localparam logic [31:0]      HeapBytes   = 32'(HeapBytesInt);
  localparam logic [31:0]      BlockBytes  = 32'(BLOCK_BYTES);
  localparam logic [DivW-1:0]  RoundUp     = DivW'(BLOCK_BYTES - 1);
  localparam logic [CntW-1:0]  BlockTotalC = CntW'(BLOCK_TOTAL);
  localparam logic [IdxW-1:0]  LastIdx     = IdxW'(BLOCK_TOTAL - 1);
  localparam logic [MarkW-1:0] MarkFree    = '0;
  localparam logic [MarkW-1:0] MarkCont    = '1;

  state_e          state_q, state_d;
  logic [31:0]     base_q;
  logic            cmd_q, cmd_d;
  logic [CntW-1:0] need_q, need_d;
  logic [CntW-1:0] run_q, run_d;
  logic [IdxW-1:0] start_q, start_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] end_q, end_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  status_e         res_status_q, res_status_d;
  logic [31:0]     res_addr_q, res_addr_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_status_q;
  logic [31:0]     out_addr_q;
  logic            out_load;

  // block table memory
  logic [MarkW-1:0] marks_mem [BLOCK_TOTAL];
  logic [MarkW-1:0] mem_rdata_q;
  logic [IdxW-1:0]  mem_raddr;
  logic [IdxW-1:0]  mem_waddr;
  logic [MarkW-1:0] mem_wdata;
  logic             mem_we;

  // divider
  logic            div_start;
  logic [DivW-1:0] div_dividend;
  logic            div_done;
  logic [DivW-1:0] div_quot;

  // helpers
  logic              req_fire;
  logic [31:0]       free_offset;
  logic [CntW-1:0]   run_inc;
  logic [IdxW-1:0]   start_nxt;
  logic [CntW-1:0]   ptr_inc;
  logic [CntW:0]     rel_sum;

  ffba_cdiv #(
    .DIVIDEND_W (DivW),
    .DIVISOR    (BLOCK_BYTES)
  ) u_cdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BASE_ADDRESS) ? base_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_ADDRESS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_BASE_ADDRESS)) begin
      base_q <= pwdata;
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign free_offset = req_i.free_address - base_q;
  assign run_inc     = run_q + 1'b1;
  assign start_nxt   = (run_q == '0) ? pend_idx_q : start_q;
  assign ptr_inc     = ptr_q + 1'b1;
  assign rel_sum     = (CntW+1)'(start_q) + (CntW+1)'(mem_rdata_q[CntW-1:0]);
  assign out_load    = (state_q == S_RESP) && (!out_valid_q || rsp_o.ready);

  // sequencer: next state and memory control
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    need_d       = need_q;
    run_d        = run_q;
    start_d      = start_q;
    ptr_d        = ptr_q;
    end_d        = end_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    mem_raddr    = ptr_q[IdxW-1:0];
    mem_waddr    = ptr_q[IdxW-1:0];
    mem_wdata    = MarkFree;
    mem_we       = 1'b0;
    div_start    = 1'b0;
    div_dividend = DivW'(req_i.alloc_bytes) + RoundUp;
    case (state_q)
      // write every entry free after reset
      S_CLEAR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_inc;
        if (ptr_q[IdxW-1:0] == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      // take a request beat, screen sizes and addresses
      S_IDLE: begin
        if (req_fire) begin
          cmd_d      = req_i.cmd;
          res_addr_d = '0;
          if (req_i.cmd == CMD_ALLOC) begin
            if ((req_i.alloc_bytes == '0) || ({16'h0, req_i.alloc_bytes} > HeapBytes)) begin
              res_status_d = STATUS_BAD_SIZE;
              state_d      = S_RESP;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end else begin
            div_dividend = DivW'(free_offset);
            if (free_offset >= HeapBytes) begin
              res_status_d = STATUS_IGNORED;
              state_d      = S_RESP;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
        end
      end
      // block count for allocate, block index for free
      S_DIV: begin
        if (div_done) begin
          if (cmd_q == CMD_ALLOC) begin
            need_d  = div_quot[CntW-1:0];
            run_d   = '0;
            ptr_d   = '0;
            state_d = S_SCAN;
          end else begin
            mem_raddr = div_quot[IdxW-1:0];
            start_d   = div_quot[IdxW-1:0];
            state_d   = S_FREE_CHK;
          end
        end
      end
      // read one entry per cycle, check the entry read the cycle before
      S_SCAN: begin
        if (ptr_q != BlockTotalC) begin
          pend_d     = 1'b1;
          pend_idx_d = ptr_q[IdxW-1:0];
          ptr_d      = ptr_inc;
        end
        if (pend_q) begin
          if (mem_rdata_q == MarkFree) begin
            start_d = start_nxt;
            run_d   = run_inc;
            if (run_inc == need_q) begin
              pend_d  = 1'b0;
              ptr_d   = CntW'(start_nxt);
              end_d   = CntW'(start_nxt) + need_q;
              state_d = S_MARK;
            end else if (pend_idx_q == LastIdx) begin
              res_status_d = STATUS_NO_FIT;
              state_d      = S_RESP;
            end
          end else begin
            run_d = '0;
            if (pend_idx_q == LastIdx) begin
              res_status_d = STATUS_NO_FIT;
              state_d      = S_RESP;
            end
          end
        end
      end
      // head gets the run length, the rest the continuation mark
      S_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = (ptr_q[IdxW-1:0] == start_q) ? MarkW'(need_q) : MarkCont;
        ptr_d     = ptr_inc;
        if (ptr_inc == end_q) begin
          res_status_d = STATUS_OK;
          res_addr_d   = base_q + 32'(start_q) * BlockBytes;
          state_d      = S_RESP;
        end
      end
      // only a run head may be freed
      S_FREE_CHK: begin
        if ((mem_rdata_q == MarkFree) || (mem_rdata_q == MarkCont)) begin
          res_status_d = STATUS_IGNORED;
          state_d      = S_RESP;
        end else begin
          ptr_d   = CntW'(start_q);
          end_d   = (rel_sum > (CntW+1)'(BLOCK_TOTAL)) ? BlockTotalC : rel_sum[CntW-1:0];
          state_d = S_RELEASE;
        end
      end
      // clear the run one entry per cycle
      S_RELEASE: begin
        mem_we = 1'b1;
        ptr_d  = ptr_inc;
        if (ptr_inc == end_q) begin
          res_status_d = STATUS_OK;
          state_d      = S_RESP;
        end
      end
      // hand the result to the output register once it is free
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
    end
  end

  // working registers of the current request
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    need_q       <= need_d;
    run_q        <= run_d;
    start_q      <= start_d;
    end_q        <= end_d;
    pend_idx_q   <= pend_idx_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
  end

  // block table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      marks_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= marks_mem[mem_raddr];
  end

  // response output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.result_address = out_addr_q;

  `FFBA_ASSERT(a_div_done_in_div, div_done |-> (state_q == S_DIV), "early divider done")
  `FFBA_ASSERT(a_run_le_need, (state_q == S_SCAN) |-> (run_q <= need_q), "run count past need")
  `FFBA_ASSERT(a_mark_in_table, (state_q == S_MARK) |-> (ptr_q < BlockTotalC), "mark overrun")
  `FFBA_ASSERT(a_release_in_table, (state_q == S_RELEASE) |-> (ptr_q < end_q), "release overrun")

endmodule
